// ===== design/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// LFU store package
// Shared payload types and constants for the LFU key/value store.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned CapW = 4;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef struct packed {
    logic            operation;
    logic [KeyW-1:0] key;
    logic [KeyW-1:0] value;
  } req_t;

  typedef struct packed {
    logic            found;
    logic [KeyW-1:0] read_value;
    logic            evicted;
    logic [KeyW-1:0] evicted_key;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RESULT
  } state_e;

endpackage

// ===== design/lfu_stream_if.sv =====
// ----------------------------------------------------------------------------
// LFU stream interface
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface lfu_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/lfu_cell.sv =====
// ----------------------------------------------------------------------------
// LFU cell
// One store slot. It compares the key, competes in the victim chain and
// applies the update that the controller broadcasts.
// ----------------------------------------------------------------------------
module lfu_cell #(
  parameter int unsigned CountBits = 16,
  parameter int unsigned RankBits  = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [lfu_pkg::KeyW-1:0] key_i,
  input  logic [lfu_pkg::KeyW-1:0] value_i,
  // victim chain from the previous cell
  input  logic                  chain_have_i,
  input  logic [CountBits-1:0]  chain_cnt_i,
  input  logic [RankBits-1:0]   chain_rank_i,
  input  logic [lfu_pkg::KeyW-1:0] chain_key_i,
  output logic                  chain_have_o,
  output logic [CountBits-1:0]  chain_cnt_o,
  output logic [RankBits-1:0]   chain_rank_o,
  output logic [lfu_pkg::KeyW-1:0] chain_key_o,
  output logic                  chain_sel_o,
  // status
  output logic                  valid_o,
  output logic                  match_o,
  output logic [lfu_pkg::KeyW-1:0] data_o,
  output logic [RankBits-1:0]   rank_o,
  // update commands
  input  logic                  raise_i,
  input  logic                  write_data_i,
  input  logic                  insert_i,
  input  logic                  evict_i,
  input  logic                  leave_en_i,
  input  logic [RankBits-1:0]   leave_rank_i,
  input  logic [RankBits-1:0]   new_rank_i
);
  import lfu_pkg::*;

  logic                 valid_q;
  logic [KeyW-1:0]      key_q, data_q;
  logic [CountBits-1:0] cnt_q;
  logic [RankBits-1:0]  rank_q;
  logic                 better;

  assign valid_o = valid_q;
  assign match_o = valid_q && (key_q == key_i);
  assign data_o  = data_q;
  assign rank_o  = rank_q;

  // Victim chain: a valid cell wins by lower count, then by lower rank.
  assign better = valid_q && (!chain_have_i || (cnt_q < chain_cnt_i) ||
                  ((cnt_q == chain_cnt_i) && (rank_q < chain_rank_i)));
  assign chain_sel_o  = better;
  assign chain_have_o = chain_have_i || valid_q;
  assign chain_cnt_o  = better ? cnt_q : chain_cnt_i;
  assign chain_rank_o = better ? rank_q : chain_rank_i;
  assign chain_key_o  = better ? key_q : chain_key_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (insert_i) begin
      valid_q <= 1'b1;
    end else if (evict_i) begin
      valid_q <= 1'b0;
    end
  end

  // Slot payload, count and recency rank.
  always_ff @(posedge clk_i) begin
    if (insert_i) begin
      key_q  <= key_i;
      data_q <= value_i;
      cnt_q  <= CountBits'(1);
      rank_q <= new_rank_i;
    end else if (raise_i) begin
      if (write_data_i) begin
        data_q <= value_i;
      end
      if (cnt_q != '1) begin
        cnt_q <= cnt_q + CountBits'(1);
      end
      rank_q <= new_rank_i;
    end else if (leave_en_i && valid_q && (rank_q > leave_rank_i)) begin
      rank_q <= rank_q - RankBits'(1);
    end
  end

endmodule

// ===== design/lfu_cache_store_unit.sv =====
// ----------------------------------------------------------------------------
// LFU cache store unit
// An input beat passes through a row update state and then a result state.
// A new item is accepted only after the previous result beat has been taken;
// accept, row update and result beat are sequential, and output stalls delay it.
// The output beat is held in a result register until taken.
// Reset: all slots invalid, capacity 8, no result pending.
// ----------------------------------------------------------------------------
module lfu_cache_store_unit #(
  parameter int unsigned ENTRIES    = 8,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [lfu_pkg::CapW-1:0] cfg_wdata_i,
  lfu_stream_if.sink               in_if,
  lfu_stream_if.source             out_if
);
  import lfu_pkg::*;

  localparam int unsigned RankBits = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Wide enough for both the occupancy count and the capacity register.
  localparam int unsigned OccBits  = ($clog2(ENTRIES + 1) > CapW) ?
                                     $clog2(ENTRIES + 1) : CapW;

  state_e state_q, state_d;
  logic [CapW-1:0] cap_q;
  req_t            req_q;
  rsp_t            rsp_q, rsp_d;

  logic [ENTRIES:0]                 ch_have;
  logic [COUNT_BITS-1:0]            ch_cnt  [ENTRIES+1];
  logic [RankBits-1:0]              ch_rank [ENTRIES+1];
  logic [KeyW-1:0]                  ch_key  [ENTRIES+1];
  logic [ENTRIES-1:0]               sel, vld, mt;
  logic [KeyW-1:0]                  data [ENTRIES];
  logic [RankBits-1:0]              rank [ENTRIES];

  logic [ENTRIES-1:0] raise, insert, evict, victim, free_one;
  logic               leave_en;
  logic [RankBits-1:0] leave_rank, new_rank;
  logic               found, full, do_evict, do_insert, upd;
  logic [KeyW-1:0]    hit_data;
  logic [RankBits-1:0] hit_rank;
  logic [OccBits-1:0] occ, eff_cap;

  assign ch_have[0] = 1'b0;
  assign ch_cnt[0]  = '0;
  assign ch_rank[0] = '0;
  assign ch_key[0]  = '0;

  // Row of slot cells.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(.CountBits(COUNT_BITS), .RankBits(RankBits)) u_cell (
      .clk_i, .rst_ni,
      .key_i(req_q.key), .value_i(req_q.value),
      .chain_have_i(ch_have[g]), .chain_cnt_i(ch_cnt[g]),
      .chain_rank_i(ch_rank[g]), .chain_key_i(ch_key[g]),
      .chain_have_o(ch_have[g+1]), .chain_cnt_o(ch_cnt[g+1]),
      .chain_rank_o(ch_rank[g+1]), .chain_key_o(ch_key[g+1]),
      .chain_sel_o(sel[g]),
      .valid_o(vld[g]), .match_o(mt[g]), .data_o(data[g]), .rank_o(rank[g]),
      .raise_i(raise[g]), .write_data_i(req_q.operation == OP_PUT),
      .insert_i(insert[g]), .evict_i(evict[g]),
      .leave_en_i(leave_en), .leave_rank_i(leave_rank), .new_rank_i(new_rank)
    );
  end

  // Victim is the last cell that won in the chain; first hit and first free.
  always_comb begin
    logic taken, fhit, ffree;
    taken    = 1'b0;
    fhit     = 1'b0;
    ffree    = 1'b0;
    victim   = '0;
    free_one = '0;
    hit_data = '0;
    hit_rank = '0;
    occ      = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (sel[i] && !taken) begin
        victim[i] = 1'b1;
        taken = 1'b1;
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (mt[i] && !fhit) begin
        fhit = 1'b1;
        hit_data = data[i];
        hit_rank = rank[i];
      end
      occ = occ + OccBits'(vld[i]);
    end
    found = fhit;
    eff_cap = (OccBits'(cap_q) > OccBits'(ENTRIES)) ? OccBits'(ENTRIES) :
              OccBits'(cap_q);
    full      = occ >= eff_cap;
    do_insert = (req_q.operation == OP_PUT) && (eff_cap != '0) && !found;
    do_evict  = do_insert && full && ch_have[ENTRIES];
    // First free slot after a possible eviction.
    for (int i = 0; i < ENTRIES; i++) begin
      if ((!vld[i] || (do_evict && victim[i])) && !ffree) begin
        free_one[i] = 1'b1;
        ffree = 1'b1;
      end
    end
  end

  // Update commands for the row.
  always_comb begin
    logic raise_any;
    upd       = (state_q == ST_UPDATE);
    raise_any = found && ((req_q.operation == OP_GET) || (eff_cap != '0));
    raise     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      raise[i] = upd && raise_any && mt[i] && (rank[i] == hit_rank);
    end
    insert   = (upd && do_insert) ? free_one : '0;
    evict    = (upd && do_evict) ? victim : '0;
    leave_en = upd && (raise_any || do_evict);
    leave_rank = raise_any ? hit_rank : ch_rank[ENTRIES];
    new_rank = raise_any ? RankBits'(occ - OccBits'(1)) :
               (do_evict ? RankBits'(occ - OccBits'(1)) : RankBits'(occ));
  end

  // Result of the current item.
  always_comb begin
    rsp_d = '0;
    rsp_d.found = found;
    if (req_q.operation == OP_GET) begin
      rsp_d.read_value = found ? hit_data : '1;
    end else begin
      rsp_d.evicted     = do_evict;
      rsp_d.evicted_key = do_evict ? ch_key[ENTRIES] : '0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_if.valid) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_RESULT;
      ST_RESULT: if (out_if.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_if.ready  = (state_q == ST_IDLE);
    out_if.valid = (state_q == ST_RESULT);
    out_if.data  = rsp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= CapW'(8);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      req_q <= in_if.data;
    end
    if (upd) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

// ===== design/lfu_checker.sv =====
// ----------------------------------------------------------------------------
// LFU checker
// Port-level checks of the store's sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input lfu_pkg::rsp_t       out_data_i
);
  import lfu_pkg::*;

  // No new beat is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken while result pending");

  // A beat taken leads to a result once the row update state has passed.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> ##1 out_valid_i) else $error("result missing");

  // Evicted key is zero when nothing was evicted.
  a_evkey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_data_i.evicted) |-> (out_data_i.evicted_key == '0))
    else $error("stray evicted key");

  // A held result stays stable.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_data_i)) else $error("result changed");

endmodule

bind lfu_cache_store_unit lfu_checker u_lfu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);
